// ===== design/aotde_pkg.sv =====
// Shared types, constants and region tables for the AOT40 diurnal estimate unit.
package aotde_pkg;

	localparam int NUM_REGIONS = 5;
	localparam int NUM_HOURS   = 13;
	localparam int HOUR_FIRST  = 6;

	localparam logic [2:0] RG_NA_EAST  = 3'd0;
	localparam logic [2:0] RG_NA_WEST  = 3'd1;
	localparam logic [2:0] RG_NA_NORTH = 3'd2;
	localparam logic [2:0] RG_NA_OTHER = 3'd3;
	localparam logic [2:0] RG_EURASIA  = 3'd4;
	localparam logic [2:0] RG_NONE     = 3'd5;

	localparam logic [1:0] CONT_OTHER = 2'd0;
	localparam logic [1:0] CONT_NAM   = 2'd1;
	localparam logic [1:0] CONT_EUR   = 2'd2;
	localparam logic [1:0] CONT_ASIA  = 2'd3;

	localparam logic [3:0] MONTH_FIRST_ACTIVE = 4'd4;
	localparam logic [3:0] MONTH_LAST_ACTIVE  = 4'd9;

	// Eurasia amplitude numerator: 757200 - 104*lat, then (n+50)/100
	localparam logic signed [22:0] EA_BASE  = 23'sd757200;
	localparam logic signed [22:0] EA_SLOPE = 23'sd104;
	localparam logic signed [22:0] EA_ROUND = 23'sd50;
	// divide by 100 as multiply by ceil(2^29/100), exact below 2^22
	localparam logic [22:0] RECIP_K     = 23'd5368710;
	localparam int          RECIP_SHIFT = 29;

	localparam logic signed [18:0] THRESH   = 19'sd4000;
	localparam logic [24:0]        EXPO_MAX = 25'h1FFFFFF;

	typedef struct packed {
		logic [2:0]  region;
		logic [21:0] amp_num;
		logic [15:0] ozone;
		logic        active;
		logic        found;
	} cell_word_t;

	typedef struct packed {
		logic [24:0] expo;
		logic        found;
	} result_t;

	function automatic int tmin_of(input int r);
		case (r)
			RG_NA_WEST, RG_EURASIA: tmin_of = 5;
			default:                tmin_of = 6;
		endcase
	endfunction

	function automatic int tmax_of(input int r);
		case (r)
			RG_NA_NORTH: tmax_of = 17;
			RG_NA_OTHER: tmax_of = 16;
			default:     tmax_of = 15;
		endcase
	endfunction

	function automatic logic [14:0] amp_const(input logic [2:0] r);
		unique case (r)
			RG_NA_EAST:  amp_const = 15'd1280;
			RG_NA_WEST:  amp_const = 15'd1100;
			RG_NA_NORTH: amp_const = 15'd430;
			RG_NA_OTHER: amp_const = 15'd790;
			default:     amp_const = 15'd0;
		endcase
	endfunction

	// hour is on the rising side of the triangle
	function automatic bit rising(input int r, input int k);
		rising = (k >= tmin_of(r)) && (k < tmax_of(r));
	endfunction

	function automatic int m_of(input int r, input int k);
		int m;
		m = 2 * k - (tmin_of(r) + tmax_of(r));
		if (k < tmin_of(r))
			m = m + 24;
		else if (k >= tmax_of(r))
			m = m - 24;
		m_of = m;
	endfunction

endpackage

// ===== design/aotde_fifo.sv =====
// Small first-word-fall-through queue built from registers.
module aotde_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) && (wr_ptr_q[AW] != rd_ptr_q[AW]);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q[AW-1:0]] <= wdata;
	end
endmodule

// ===== design/aotde_front.sv =====
// Region classification, active month check and Eurasia amplitude numerator.
module aotde_front (
	input  logic signed [15:0]    longitude,
	input  logic signed [14:0]    latitude,
	input  logic [1:0]            continent,
	input  logic [15:0]           ozone_mean,
	input  logic [3:0]            month_index,
	output aotde_pkg::cell_word_t word
);
	logic signed [22:0] lat_x;
	logic signed [22:0] ea_num;
	logic               lat_10_90;
	logic               r0_hit;
	logic               r1_hit;
	logic               r2_hit;
	logic               r3_hit;
	logic               r4_hit;
	logic [2:0]         region;

	assign lat_x     = {{8{latitude[14]}}, latitude};
	assign ea_num    = aotde_pkg::EA_BASE - aotde_pkg::EA_SLOPE * lat_x;
	assign lat_10_90 = (latitude > 15'sd1000) && (latitude < 15'sd9000);

	assign r0_hit = (longitude > -16'sd9000) && (longitude < -16'sd5500) && lat_10_90;
	assign r1_hit = (longitude > -16'sd12400) && (longitude < -16'sd11200)
		&& (latitude > 15'sd4700) && (latitude < 15'sd5500);
	assign r2_hit = (longitude > -16'sd18000) && (longitude < -16'sd12300)
		&& (latitude > 15'sd5300) && (latitude < 15'sd9000);
	assign r3_hit = (longitude > -16'sd18000) && (longitude < -16'sd9000) && lat_10_90;
	assign r4_hit = (longitude > -16'sd1500) && (longitude < 16'sd18000) && lat_10_90;

	always_comb begin
		region = aotde_pkg::RG_NONE;
		unique case (continent)
			aotde_pkg::CONT_NAM: begin
				if (r0_hit)
					region = aotde_pkg::RG_NA_EAST;
				else if (r1_hit)
					region = aotde_pkg::RG_NA_WEST;
				else if (r2_hit)
					region = aotde_pkg::RG_NA_NORTH;
				else if (r3_hit)
					region = aotde_pkg::RG_NA_OTHER;
			end
			aotde_pkg::CONT_EUR, aotde_pkg::CONT_ASIA: begin
				if (r4_hit)
					region = aotde_pkg::RG_EURASIA;
			end
			default: region = aotde_pkg::RG_NONE;
		endcase
	end

	always_comb begin
		word.region  = region;
		// clip at zero: a zero numerator yields a zero amplitude
		word.amp_num = (ea_num > 23'sd0) ? 22'(ea_num + aotde_pkg::EA_ROUND) : 22'd0;
		word.ozone   = ozone_mean;
		word.found   = (region != aotde_pkg::RG_NONE);
		word.active  = (region != aotde_pkg::RG_NONE)
			&& (month_index >= aotde_pkg::MONTH_FIRST_ACTIVE)
			&& (month_index <= aotde_pkg::MONTH_LAST_ACTIVE);
	end
endmodule

// ===== design/aotde_back.sv =====
// Six-stage datapath: amplitude, hourly offsets, excess over threshold, sum and scale.
module aotde_back #(
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  aotde_pkg::cell_word_t in_word,
	output logic                  out_valid,
	output aotde_pkg::result_t    out_word
);
	localparam int NH  = aotde_pkg::NUM_HOURS;
	localparam int NR  = aotde_pkg::NUM_REGIONS;
	localparam int CMW = COEF_FRAC_BITS + 4;
	localparam int PW  = 16 + CMW;
	localparam logic signed [PW-1:0] HALF = PW'(longint'(1) << COEF_FRAC_BITS);

	logic signed [CMW-1:0] cm_tab [NH][NR];

	// per hour and region: slope coefficient times hour offset, fixed at elaboration
	for (genvar l = 0; l < NH; l++) begin : g_lane_tab
		for (genvar r = 0; r < NR; r++) begin : g_reg_tab
			localparam int     K  = aotde_pkg::HOUR_FIRST + l;
			localparam int     LU = aotde_pkg::tmax_of(r) - aotde_pkg::tmin_of(r);
			localparam int     LD = 24 - LU;
			localparam longint CU = ((longint'(2) << COEF_FRAC_BITS) + LU / 2) / LU;
			localparam longint CD = ((longint'(2) << COEF_FRAC_BITS) + LD / 2) / LD;
			localparam longint MV = longint'(aotde_pkg::m_of(r, K));
			localparam longint CV = aotde_pkg::rising(r, K) ? CU * MV : -CD * MV;
			assign cm_tab[l][r] = CMW'(CV);
		end
	end

	// stage 1: amplitude and per-lane coefficient
	logic [44:0]           amp_mul;
	logic [14:0]           amp_c;
	logic                  valid_s1;
	logic [14:0]           amp_s1;
	logic signed [CMW-1:0] cm_s1 [NH];
	logic [15:0]           ozone_s1;
	logic                  active_s1;
	logic                  found_s1;

	assign amp_mul = {23'd0, in_word.amp_num} * {22'd0, aotde_pkg::RECIP_K};
	assign amp_c   = (in_word.region == aotde_pkg::RG_EURASIA)
		? amp_mul[aotde_pkg::RECIP_SHIFT +: 15] : aotde_pkg::amp_const(in_word.region);

	always_ff @(posedge clk) begin
		amp_s1    <= amp_c;
		ozone_s1  <= in_word.ozone;
		active_s1 <= in_word.active;
		found_s1  <= in_word.found;
		for (int l = 0; l < NH; l++) begin
			if (in_word.region <= aotde_pkg::RG_EURASIA)
				cm_s1[l] <= cm_tab[l][in_word.region];
			else
				cm_s1[l] <= '0;
		end
	end

	// stage 2: amplitude times coefficient
	logic                 valid_s2;
	logic signed [PW-1:0] prod_s2 [NH];
	logic [15:0]          ozone_s2;
	logic                 active_s2;
	logic                 found_s2;

	always_ff @(posedge clk) begin
		ozone_s2  <= ozone_s1;
		active_s2 <= active_s1;
		found_s2  <= found_s1;
		for (int l = 0; l < NH; l++)
			prod_s2[l] <= $signed({1'b0, amp_s1}) * cm_s1[l];
	end

	// stage 3: hourly ozone and excess over threshold
	logic        valid_s3;
	logic [16:0] ex_c [NH];
	logic [16:0] ex_s3 [NH];
	logic        active_s3;
	logic        found_s3;

	for (genvar l = 0; l < NH; l++) begin : g_excess
		logic signed [PW-1:0] rnd;
		logic signed [PW-1:0] off_full;
		logic signed [18:0]   oz;
		assign rnd      = prod_s2[l] + HALF;
		assign off_full = rnd >>> (COEF_FRAC_BITS + 1);
		assign oz       = $signed({3'b000, ozone_s2}) + off_full[18:0];
		assign ex_c[l]  = (oz >= aotde_pkg::THRESH) ? 17'(oz - aotde_pkg::THRESH) : 17'd0;
	end

	always_ff @(posedge clk) begin
		active_s3 <= active_s2;
		found_s3  <= found_s2;
		for (int l = 0; l < NH; l++)
			ex_s3[l] <= ex_c[l];
	end

	// stage 4: partial sums over three groups of hours
	logic        valid_s4;
	logic [19:0] part_c [3];
	logic [19:0] part_s4 [3];
	logic        active_s4;
	logic        found_s4;

	always_comb begin
		part_c[0] = 20'(ex_s3[0]) + 20'(ex_s3[1]) + 20'(ex_s3[2]) + 20'(ex_s3[3]);
		part_c[1] = 20'(ex_s3[4]) + 20'(ex_s3[5]) + 20'(ex_s3[6]) + 20'(ex_s3[7]);
		part_c[2] = 20'(ex_s3[8]) + 20'(ex_s3[9]) + 20'(ex_s3[10]) + 20'(ex_s3[11])
			+ 20'(ex_s3[12]);
	end

	always_ff @(posedge clk) begin
		part_s4   <= part_c;
		active_s4 <= active_s3;
		found_s4  <= found_s3;
	end

	// stage 5: total
	logic        valid_s5;
	logic [20:0] total_s5;
	logic        active_s5;
	logic        found_s5;

	always_ff @(posedge clk) begin
		total_s5  <= 21'(part_s4[0]) + 21'(part_s4[1]) + 21'(part_s4[2]);
		active_s5 <= active_s4;
		found_s5  <= found_s4;
	end

	// stage 6: times 31, saturate, zero outside the season
	logic [25:0]        scaled;
	logic               valid_s6;
	aotde_pkg::result_t res_s6;

	assign scaled = ({5'd0, total_s5} << 5) - {5'd0, total_s5};

	always_ff @(posedge clk) begin
		res_s6.found <= found_s5;
		if (!active_s5)
			res_s6.expo <= '0;
		else if (scaled[25])
			res_s6.expo <= aotde_pkg::EXPO_MAX;
		else
			res_s6.expo <= scaled[24:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign out_valid = valid_s6;
	assign out_word  = res_s6;
endmodule

// ===== design/ozone_aot40_diurnal_estimate_unit.sv =====
// An accepted push goes through the input queue and the six back stages to the result queue.
// Throughput: one word per cycle; the back datapath is a six-stage pipeline that
// issues from the input queue whenever a slot in the result queue can be reserved.
// Stalls on pop hold words in the result queue, then the input queue, then full rises.
// Reset (arst_n low) empties both queues and clears the pipeline valid bits.
// Result words come out in push order.
module ozone_aot40_diurnal_estimate_unit #(
	parameter int COEF_FRAC_BITS = 16,
	parameter int IN_DEPTH       = 4,
	parameter int OUT_DEPTH      = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] longitude,
	input  logic signed [14:0] latitude,
	input  logic [1:0]         continent,
	input  logic [15:0]        ozone_mean,
	input  logic [3:0]         month_index,
	output logic               empty,
	input  logic               pop,
	output logic [24:0]        exposure_index,
	output logic               region_found
);
	localparam int CW = $clog2(OUT_DEPTH + 1);

	aotde_pkg::cell_word_t front_word;
	aotde_pkg::cell_word_t q_word;
	logic                  q_empty;
	logic                  issue;
	logic                  back_valid;
	aotde_pkg::result_t    back_word;
	aotde_pkg::result_t    out_word;
	logic                  out_full;
	logic [CW-1:0]         credit_q;
	logic                  res_pop;

	aotde_front u_front (
		.longitude   (longitude),
		.latitude    (latitude),
		.continent   (continent),
		.ozone_mean  (ozone_mean),
		.month_index (month_index),
		.word        (front_word)
	);

	aotde_fifo #(
		.DEPTH (IN_DEPTH),
		.WIDTH ($bits(aotde_pkg::cell_word_t))
	) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_word),
		.full   (full),
		.pop    (issue),
		.rdata  (q_word),
		.empty  (q_empty)
	);

	// reserve a result slot for every word in flight
	assign res_pop = pop && !empty;
	assign issue   = !q_empty && (credit_q < CW'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			credit_q <= '0;
		else
			credit_q <= credit_q + CW'(issue) - CW'(res_pop);
	end

	aotde_back #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (issue),
		.in_word   (q_word),
		.out_valid (back_valid),
		.out_word  (back_word)
	);

	aotde_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH ($bits(aotde_pkg::result_t))
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (back_valid),
		.wdata  (back_word),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_word),
		.empty  (empty)
	);

	assign exposure_index = out_word.expo;
	assign region_found   = out_word.found;
endmodule

// ===== bench/ozone_aot40_diurnal_estimate_unit_test.sv =====
// Testbench for the AOT40 diurnal estimate unit: directed and random cells against a predictor.
module ozone_aot40_diurnal_estimate_unit_test;

	localparam int FRAC       = 16;
	localparam int WDOG_LIMIT = 4000;

	typedef struct {
		logic [24:0] expo;
		logic        found;
	} aot_word_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               push = 0;
	logic               pop = 0;
	logic signed [15:0] longitude = 0;
	logic signed [14:0] latitude = 0;
	logic [1:0]         continent = aotde_pkg::CONT_OTHER;
	logic [15:0]        ozone_mean = 0;
	logic [3:0]         month_index = 0;
	logic               full, empty, region_found;
	logic [24:0]        exposure_index;

	aot_word_t expected_words[$];
	int  mismatches = 0;
	bit  hold_rx = 0;
	bit  no_idle = 0;
	int  wdog = 0;

	// region table: lon_lo, lon_hi, lat_lo, lat_hi, tmin, tmax, amplitude
	int rg_lon_lo[5] = '{-9000, -12400, -18000, -18000, -1500};
	int rg_lon_hi[5] = '{-5500, -11200, -12300, -9000, 18000};
	int rg_lat_lo[5] = '{1000, 4700, 5300, 1000, 1000};
	int rg_lat_hi[5] = '{9000, 5500, 9000, 9000, 9000};
	int rg_tmin[5]   = '{6, 5, 6, 6, 5};
	int rg_tmax[5]   = '{15, 15, 17, 16, 15};
	int rg_amp[5]    = '{1280, 1100, 430, 790, 0};

	ozone_aot40_diurnal_estimate_unit #(.COEF_FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.longitude(longitude), .latitude(latitude), .continent(continent),
		.ozone_mean(ozone_mean), .month_index(month_index),
		.empty(empty), .pop(pop),
		.exposure_index(exposure_index), .region_found(region_found)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit in_rule(int r, int lon, int lat);
		return lon > rg_lon_lo[r] && lon < rg_lon_hi[r]
			&& lat > rg_lat_lo[r] && lat < rg_lat_hi[r];
	endfunction

	function automatic aot_word_t predict_exposure(int lon, int lat, logic [1:0] cont,
			logic [15:0] oz, logic [3:0] mon);
		aot_word_t w;
		int rg;
		longint amp, c_up, c_dn, c, m, level, sum, num, len_up, len_dn;
		rg = aotde_pkg::RG_NONE;
		if (cont == aotde_pkg::CONT_NAM) begin
			for (int i = aotde_pkg::RG_NA_OTHER; i >= 0; i--)
				if (in_rule(i, lon, lat))
					rg = i;
		end else if (cont == aotde_pkg::CONT_EUR || cont == aotde_pkg::CONT_ASIA) begin
			if (in_rule(aotde_pkg::RG_EURASIA, lon, lat))
				rg = aotde_pkg::RG_EURASIA;
		end
		w.found = (rg != aotde_pkg::RG_NONE);
		w.expo = 0;
		if (w.found && mon >= aotde_pkg::MONTH_FIRST_ACTIVE
				&& mon <= aotde_pkg::MONTH_LAST_ACTIVE) begin
			amp = rg_amp[rg];
			if (rg == aotde_pkg::RG_EURASIA) begin
				num = 757200 - 104 * longint'(lat);
				amp = (num <= 0) ? 0 : (num + 50) / 100;
			end
			len_up = rg_tmax[rg] - rg_tmin[rg];
			len_dn = 24 - len_up;
			c_up = ((longint'(2) << FRAC) + len_up / 2) / len_up;
			c_dn = ((longint'(2) << FRAC) + len_dn / 2) / len_dn;
			sum = 0;
			for (int k = 6; k <= 18; k++) begin
				m = 2 * k - (rg_tmin[rg] + rg_tmax[rg]);
				c = -c_dn;
				if (k < rg_tmin[rg])
					m += 24;
				else if (k < rg_tmax[rg])
					c = c_up;
				else
					m -= 24;
				level = longint'(oz) + ((amp * c * m + (longint'(1) << FRAC)) >>> (FRAC + 1));
				if (level >= 4000)
					sum += level - 4000;
			end
			sum *= 31;
			w.expo = (sum > 33554431) ? 25'h1FFFFFF : sum[24:0];
		end
		return w;
	endfunction

	task automatic send_cell(int lon, int lat, logic [1:0] cont, logic [15:0] oz,
			logic [3:0] mon);
		int gap;
		gap = no_idle ? 0 : $urandom_range(13);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		longitude <= lon[15:0];
		latitude <= lat[14:0];
		continent <= cont;
		ozone_mean <= oz;
		month_index <= mon;
		@(posedge clk);
		while (full)
			@(posedge clk);
		expected_words.push_back(predict_exposure(int'($signed(lon[15:0])),
			int'($signed(lat[14:0])), cont, oz, mon));
	endtask

	task automatic send_random_cell();
		int r, lon, lat;
		logic [15:0] oz;
		r = $urandom_range(9);
		oz = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 9000));
		if (r >= 5) begin
			// noise over every bit of every field
			send_cell(int'($signed(16'($urandom))), int'($signed(15'($urandom))),
				2'($urandom), 16'($urandom), 4'($urandom));
		end else begin
			lon = $urandom_range(rg_lon_hi[r] - rg_lon_lo[r] - 2) + rg_lon_lo[r] + 1;
			lat = $urandom_range(rg_lat_hi[r] - rg_lat_lo[r] - 2) + rg_lat_lo[r] + 1;
			send_cell(lon, lat, (r == aotde_pkg::RG_EURASIA)
				? 2'($urandom_range(aotde_pkg::CONT_EUR, aotde_pkg::CONT_ASIA))
				: aotde_pkg::CONT_NAM, oz,
				($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(4, 9)));
		end
	endtask

	// receive results
	initial begin
		aot_word_t w;
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(13);
			if (hold_rx || stall > 0) begin
				pop <= 0;
				repeat (stall) @(posedge clk);
				while (hold_rx)
					@(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: expo %0d found %0b", exposure_index, region_found);
			end else begin
				w = expected_words.pop_front();
				if (w.expo !== exposure_index || w.found !== region_found) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected expo %0d found %0b, got expo %0d found %0b",
							w.expo, w.found, exposure_index, region_found);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_LIMIT) begin
			$display("FAIL ozone_aot40_diurnal_estimate_unit");
			$finish;
		end
	end

	task automatic test_directed();
		send_cell(-7000, 4000, aotde_pkg::CONT_NAM, 6000, 6);
		send_cell(-11800, 5000, aotde_pkg::CONT_NAM, 6000, 6);
		send_cell(-15000, 7000, aotde_pkg::CONT_NAM, 6000, 7);
		send_cell(-10000, 3000, aotde_pkg::CONT_NAM, 6000, 8);
		send_cell(1000, 4500, aotde_pkg::CONT_EUR, 6000, 4);
		send_cell(10000, 1001, aotde_pkg::CONT_ASIA, 65535, 9);
		send_cell(1000, 8000, aotde_pkg::CONT_EUR, 4500, 5);
		send_cell(1000, 4500, aotde_pkg::CONT_OTHER, 6000, 6);
		send_cell(-9000, 4000, aotde_pkg::CONT_NAM, 6000, 6);
		send_cell(-8999, 1001, aotde_pkg::CONT_NAM, 6000, 6);
		send_cell(-1500, 4500, aotde_pkg::CONT_EUR, 6000, 6);
		send_cell(17999, 8999, aotde_pkg::CONT_ASIA, 6000, 6);
		send_cell(1000, 1000, aotde_pkg::CONT_EUR, 6000, 6);
		send_cell(-7000, 4000, aotde_pkg::CONT_NAM, 0, 6);
		send_cell(-7000, 4000, aotde_pkg::CONT_NAM, 65535, 3);
		send_cell(-7000, 4000, aotde_pkg::CONT_NAM, 65535, 10);
		send_cell(-7000, 4000, aotde_pkg::CONT_NAM, 65535, 0);
		send_cell(-7000, 4000, aotde_pkg::CONT_NAM, 65535, 11);
		send_cell(-7000, 4000, aotde_pkg::CONT_NAM, 65535, 12);
		send_cell(-7000, 4000, aotde_pkg::CONT_NAM, 65535, 15);
		send_cell(-32768, -16384, aotde_pkg::CONT_NAM, 6000, 6);
		send_cell(32767, 16383, aotde_pkg::CONT_ASIA, 6000, 6);
		send_cell(-18000, -9000, aotde_pkg::CONT_EUR, 6000, 6);
		send_cell(18000, 9000, aotde_pkg::CONT_ASIA, 6000, 6);
	endtask

	task automatic test_random(int n);
		repeat (n) send_random_cell();
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_rx = 1;
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
		join_none
		no_idle = 1;
		repeat (60) send_random_cell();
		no_idle = 0;
	endtask

	task automatic test_drain_pause();
		push <= 0;
		while (expected_words.size() != 0)
			@(posedge clk);
		test_random(50);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random(800);
		test_backpressure();
		test_drain_pause();
		no_idle = 1;
		test_random(200);
		no_idle = 0;
		test_random(800);
		push <= 0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("PASS ozone_aot40_diurnal_estimate_unit");
		else
			$display("FAIL ozone_aot40_diurnal_estimate_unit");
		$finish;
	end

endmodule

// ===== sim.f =====
design/aotde_pkg.sv
design/aotde_fifo.sv
design/aotde_front.sv
design/aotde_back.sv
design/ozone_aot40_diurnal_estimate_unit.sv
bench/ozone_aot40_diurnal_estimate_unit_test.sv
